// File: sv/lcdpf_pkg.sv
// Shared types, codes and constants for the RGB565 pixel stream formatter.
// No dependencies.
package lcdpf_pkg;

    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 16;
    localparam int STEP_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_PIXEL_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FG_COLOR   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BG_COLOR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COL_OFFSET = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW_OFFSET = 3'd5;

    localparam logic [1:0] MODE_MONO   = 2'd0;
    localparam logic [1:0] MODE_THRESH = 2'd1;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_WINDOW = 1'b1;

    localparam logic [15:0] CMD_COL_ADDR  = 16'h002A;
    localparam logic [15:0] CMD_ROW_ADDR  = 16'h002B;
    localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;

    localparam logic [STEP_W-1:0] WIN_COL_CMD   = 3'd0;
    localparam logic [STEP_W-1:0] WIN_COL_START = 3'd1;
    localparam logic [STEP_W-1:0] WIN_COL_END   = 3'd2;
    localparam logic [STEP_W-1:0] WIN_ROW_CMD   = 3'd3;
    localparam logic [STEP_W-1:0] WIN_ROW_START = 3'd4;
    localparam logic [STEP_W-1:0] WIN_ROW_END   = 3'd5;
    localparam logic [STEP_W-1:0] WIN_MEM_CMD   = 3'd6;
    localparam logic [STEP_W-1:0] MONO_LAST     = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [8:0] win_width;
        logic [8:0] win_height;
    } item_t;

    function automatic logic [15:0] gray_to_rgb565(input logic [7:0] g);
        gray_to_rgb565 = {g[7:3], g[7:2], g[7:3]};
    endfunction

    function automatic logic [15:0] win_end(input logic [7:0] start,
                                            input logic [8:0] size,
                                            input logic [7:0] offset);
        win_end = {8'd0, start} + {7'd0, size} - 16'd1 + {8'd0, offset};
    endfunction

endpackage

// File: sv/lcd_pixel_formatter_rgb565.sv
// Top level of the RGB565 pixel stream formatter: config registers, item hold
// register, per-word step logic and output register. Depends on lcdpf_pkg.
//
//  channel | ports            | payload
//  --------+------------------+---------------------------------------------
//  input   | s_tvalid/tready  | s_tdata: image byte and window, s_tuser: kind
//  output  | m_tvalid/tready  | m_tdata: out_word, m_tuser: is_command, m_tlast
//  config  | cfg_wr_en        | cfg_addr: register index, cfg_wr_data
//
// A request is held while its words go out at one word per cycle unless the
// output stalls: a mono byte gives 8 words, a window request 7, a threshold or
// gray byte 1, each picked by the step counter over the hold register. The
// next request is taken in the cycle the last word of the current one enters
// the output register. Reset is synchronous, active low, and restores the
// register defaults; output stalls hold the step counter and output register.
module lcd_pixel_formatter_rgb565
    import lcdpf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] data_byte, [15:8] x_start, [23:16] y_start,
    // [32:24] win_width, [41:33] win_height, [47:42] zero
    input  logic [47:0]           s_tdata,
    // [0] kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] out_word
    output logic [15:0]           m_tdata,
    // [0] is_command
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_addr,
    input  logic [REG_DATA_W-1:0] cfg_wr_data
);

    logic [1:0]  pixel_mode_reg;
    logic [15:0] fg_color_reg;
    logic [15:0] bg_color_reg;
    logic [7:0]  threshold_reg;
    logic [7:0]  col_offset_reg;
    logic [7:0]  row_offset_reg;

    item_t             item_reg;
    logic              hold_valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        m_cmd_reg;
    logic        m_last_reg;

    logic        advance;
    logic        load;
    logic        s_accept;
    logic [15:0] word_c;
    logic        cmd_c;
    logic        last_c;
    item_t       in_item;

    assign in_item = '{kind:       s_tuser,
                       data_byte:  s_tdata[7:0],
                       x_start:    s_tdata[15:8],
                       y_start:    s_tdata[23:16],
                       win_width:  s_tdata[32:24],
                       win_height: s_tdata[41:33]};

    always_comb begin
        word_c = 16'd0;
        cmd_c  = 1'b0;
        last_c = 1'b1;
        if (item_reg.kind == KIND_WINDOW) begin
            last_c = (step_reg == WIN_MEM_CMD);
            case (step_reg)
                WIN_COL_CMD: begin
                    word_c = CMD_COL_ADDR;
                    cmd_c  = 1'b1;
                end
                WIN_COL_START: word_c = {8'd0, item_reg.x_start} + {8'd0, col_offset_reg};
                WIN_COL_END:   word_c = win_end(item_reg.x_start, item_reg.win_width,
                                                col_offset_reg);
                WIN_ROW_CMD: begin
                    word_c = CMD_ROW_ADDR;
                    cmd_c  = 1'b1;
                end
                WIN_ROW_START: word_c = {8'd0, item_reg.y_start} + {8'd0, row_offset_reg};
                WIN_ROW_END:   word_c = win_end(item_reg.y_start, item_reg.win_height,
                                                row_offset_reg);
                default: begin
                    word_c = CMD_MEM_WRITE;
                    cmd_c  = 1'b1;
                end
            endcase
        end else begin
            case (pixel_mode_reg)
                MODE_MONO: begin
                    word_c = item_reg.data_byte[~step_reg] ? fg_color_reg : bg_color_reg;
                    last_c = (step_reg == MONO_LAST);
                end
                MODE_THRESH: begin
                    word_c = (item_reg.data_byte > threshold_reg) ? fg_color_reg
                                                                   : bg_color_reg;
                end
                default: word_c = gray_to_rgb565(item_reg.data_byte);
            endcase
        end
    end

    assign advance   = !m_valid_reg || m_tready;
    assign load      = advance && hold_valid_reg;
    assign s_tready  = !hold_valid_reg || (load && last_c);
    assign s_accept  = s_tvalid && s_tready;
    assign step_next = (load && !last_c) ? step_reg + 3'd1 : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mode_reg <= MODE_MONO;
            fg_color_reg   <= 16'hFFFF;
            bg_color_reg   <= 16'h0000;
            threshold_reg  <= 8'd128;
            col_offset_reg <= 8'd2;
            row_offset_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PIXEL_MODE: pixel_mode_reg <= cfg_wr_data[1:0];
                REG_FG_COLOR:   fg_color_reg   <= cfg_wr_data;
                REG_BG_COLOR:   bg_color_reg   <= cfg_wr_data;
                REG_THRESHOLD:  threshold_reg  <= cfg_wr_data[7:0];
                REG_COL_OFFSET: col_offset_reg <= cfg_wr_data[7:0];
                REG_ROW_OFFSET: row_offset_reg <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                hold_valid_reg <= 1'b1;
            end else if (load && last_c) begin
                hold_valid_reg <= 1'b0;
            end
            if (load) begin
                step_reg    <= step_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= in_item;
        end
        if (load) begin
            m_data_reg <= word_c;
            m_cmd_reg  <= cmd_c;
            m_last_reg <= last_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_cmd_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_step_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != '0) |-> hold_valid_reg)
        else $error("step counter running without a held request");

    a_window_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && item_reg.kind == KIND_WINDOW) |-> (step_reg <= WIN_MEM_CMD))
        else $error("window request stepped past memory-write command");

    a_cmd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg && m_cmd_reg) |-> (m_data_reg == CMD_MEM_WRITE))
        else $error("last command word is not memory write");
`endif

endmodule
